// File: rtl/ivls_pkg.sv
package ivls_pkg;

  localparam int FRAME_LINES   = 525;
  localparam int VISIBLE_LINES = 480;
  localparam int FIELD_BIT     = 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int REG_W      = 10;
  localparam int BORDER_W   = 8;
  localparam int ROW_W      = 10;
  localparam int PROW_W     = ROW_W + 1;
  localparam int KIND_W     = 3;
  localparam int LEN_W      = 2;

  localparam logic [REG_W-1:0] FIELD_LAST_RESET  = REG_W'(FRAME_LINES / 2);
  localparam logic [REG_W-1:0] VBLANK_LAST_RESET = REG_W'((FRAME_LINES - VISIBLE_LINES) / 2);
  localparam logic [REG_W-1:0] BITMAP_RESET      = REG_W'(VISIBLE_LINES / 2);

  localparam int EQ_PRE_LAST  = 3;
  localparam int VSYNC_LAST   = 6;
  localparam int EQ_POST_LAST = 8;
  localparam int EQ_SPLIT     = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_LAST  = 3'd0,
    REG_VBLANK_LAST = 3'd1,
    REG_BORDER      = 3'd2,
    REG_BITMAP      = 3'd3,
    REG_FORCE_BLANK = 3'd4
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BLANK    = 3'd0,
    KIND_EQ       = 3'd1,
    KIND_VSYNC    = 3'd2,
    KIND_EQ_BLANK = 3'd3,
    KIND_BORDER   = 3'd4,
    KIND_PIXEL    = 3'd5
  } line_kind_t;

  typedef enum logic [LEN_W-1:0] {
    LEN_FULL       = 2'd0,
    LEN_HALF       = 2'd1,
    LEN_ONE_HALF   = 2'd2
  } length_code_t;

endpackage

// File: rtl/ivls_if.sv
interface ivls_tick_if;
  logic valid;
  logic ready;
  logic line_end;

  modport source (output valid, output line_end, input ready);
  modport sink (input valid, input line_end, output ready);
endinterface

interface ivls_line_if import ivls_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] line_kind;
  logic [LEN_W-1:0]  length_code;
  logic [PROW_W-1:0] pixel_row;
  logic              buffer_select;
  logic              field_odd;

  modport source (
    output valid, output line_kind, output length_code, output pixel_row,
    output buffer_select, output field_odd, input ready
  );
  modport sink (
    input valid, input line_kind, input length_code, input pixel_row,
    input buffer_select, input field_odd, output ready
  );
endinterface

// File: rtl/interlaced_video_line_sequencer_top.sv
// Interlaced vertical line sequencer. Each item on ticks with line_end set
// marks the end of one scanline and yields exactly one item on lines that
// describes the next line to send: its kind, its length and, for pixel lines,
// the framebuffer row (2k + field) and line buffer (k & 1). Items with
// line_end clear are taken and give nothing. On acceptance of an item the
// line, row and field counters update and the result goes to an output
// register, so ticks are taken every cycle while lines.ready is high. A
// result waiting in the register with lines.ready low holds off further
// ticks until it is taken. After reset the first tick wraps to line 0 of
// an even field. Registers must be written through cfg_we/cfg_index/cfg_data
// only while no tick is in flight; the block itself does not enforce this.
module interlaced_video_line_sequencer_top import ivls_pkg::*; #(
  parameter int LINE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ivls_tick_if.sink             ticks,
  ivls_line_if.source           lines
);

  localparam int CW = (LINE_BITS + 1 > REG_W + 3) ? LINE_BITS + 1 : REG_W + 3;
  localparam logic [LINE_BITS-1:0] LINE_RESET = LINE_BITS'(FIELD_LAST_RESET);

  logic [REG_W-1:0]    field_last_line;
  logic [REG_W-1:0]    vblank_last_line;
  logic [BORDER_W-1:0] border_lines;
  logic [REG_W-1:0]    bitmap_lines;
  logic                force_blank;

  logic [LINE_BITS-1:0] line_index;
  logic [ROW_W-1:0]     row_index;
  logic                 odd_field;

  logic                 out_valid;
  line_kind_t           out_kind;
  length_code_t         out_len;
  logic [PROW_W-1:0]    out_row;
  logic                 out_bsel;
  logic                 out_odd;

  logic                 accept;
  logic                 tick;
  logic [LINE_BITS:0]   line_inc;
  logic                 wrap;
  logic [LINE_BITS-1:0] line_index_next;
  logic [ROW_W-1:0]     row_base;
  logic [ROW_W-1:0]     row_index_next;
  logic                 odd_field_next;
  logic [CW-1:0]        ln;
  logic [CW-1:0]        vb_end;
  logic [CW-1:0]        border_end;
  logic [CW-1:0]        pixel_end;
  line_kind_t           kind;
  length_code_t         len;
  logic [PROW_W-1:0]    prow;
  logic                 bsel;

  assign ticks.ready = !out_valid || lines.ready;
  assign accept      = ticks.valid && ticks.ready;
  assign tick        = accept && ticks.line_end;

  always_comb begin
    line_inc        = {1'b0, line_index} + 1'b1;
    wrap            = (CW'(line_inc) > CW'(field_last_line)) || line_inc[LINE_BITS];
    line_index_next = wrap ? '0 : line_inc[LINE_BITS-1:0];
    row_base        = wrap ? '0 : row_index;
    odd_field_next  = wrap ? ~odd_field : odd_field;
    ln              = CW'(line_index_next);
    vb_end          = CW'(vblank_last_line);
    border_end      = vb_end + CW'(border_lines);
    pixel_end       = border_end + CW'(bitmap_lines);
    kind            = KIND_BLANK;
    len             = LEN_FULL;
    prow            = '0;
    bsel            = 1'b0;
    row_index_next  = row_base;
    if (ln <= vb_end) begin
      if (ln == '0) begin
        len = odd_field_next ? LEN_FULL : LEN_HALF;
      end else if (ln <= CW'(EQ_PRE_LAST)) begin
        kind = KIND_EQ;
      end else if (ln <= CW'(VSYNC_LAST)) begin
        kind = KIND_VSYNC;
      end else if (ln <= CW'(EQ_POST_LAST)) begin
        kind = KIND_EQ;
      end else if (ln == CW'(EQ_SPLIT)) begin
        if (odd_field_next) begin
          kind = KIND_EQ;
        end else begin
          kind = KIND_EQ_BLANK;
          len  = LEN_ONE_HALF;
        end
      end
    end else if (ln <= border_end || ln > pixel_end) begin
      kind = force_blank ? KIND_BLANK : KIND_BORDER;
    end else if (!force_blank) begin
      kind           = KIND_PIXEL;
      prow           = {row_base, odd_field_next};
      bsel           = row_base[0];
      row_index_next = row_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_last_line  <= FIELD_LAST_RESET;
      vblank_last_line <= VBLANK_LAST_RESET;
      border_lines     <= '0;
      bitmap_lines     <= BITMAP_RESET;
      force_blank      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIELD_LAST:  field_last_line  <= cfg_data[REG_W-1:0];
        REG_VBLANK_LAST: vblank_last_line <= cfg_data[REG_W-1:0];
        REG_BORDER:      border_lines     <= cfg_data[BORDER_W-1:0];
        REG_BITMAP:      bitmap_lines     <= cfg_data[REG_W-1:0];
        REG_FORCE_BLANK: force_blank      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_index <= LINE_RESET;
      row_index  <= '0;
      odd_field  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (tick) begin
        line_index <= line_index_next;
        row_index  <= row_index_next;
        odd_field  <= odd_field_next;
      end
      if (ticks.ready) begin
        out_valid <= tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_kind <= kind;
      out_len  <= len;
      out_row  <= prow;
      out_bsel <= bsel;
      out_odd  <= odd_field_next;
    end
  end

  assign lines.valid         = out_valid;
  assign lines.line_kind     = out_kind;
  assign lines.length_code   = out_len;
  assign lines.pixel_row     = out_row;
  assign lines.buffer_select = out_bsel;
  assign lines.field_odd     = out_odd;

  a_no_row_off_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_PIXEL |-> out_row == '0 && !out_bsel)
    else $error("row or buffer set on a non-pixel line");

  a_row_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_PIXEL |-> out_row[0] == out_odd)
    else $error("pixel row parity does not match field");

  a_len_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_len != LEN_FULL |->
      (out_kind == KIND_BLANK && out_len == LEN_HALF && !out_odd) ||
      (out_kind == KIND_EQ_BLANK && out_len == LEN_ONE_HALF && !out_odd))
    else $error("partial line length on wrong line kind or field");

  a_wrap_field: assert property (@(posedge clk) disable iff (rst)
    tick && wrap |=> odd_field != $past(odd_field) && line_index == '0)
    else $error("field did not toggle on wrap");

endmodule
